@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, disabled in reset
`define AST_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk_i, disabled in reset
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/hlpf_pkg.sv @@
`timescale 1ns / 1ps
package hlpf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int NUM_ANGLES = 180;
  localparam int MAX_PEAKS  = 32;
  localparam int VOTE_BITS  = 16;

  localparam int ROWS_MAX = 2 * (MAX_WIDTH + MAX_HEIGHT);
  localparam int ROW_W    = $clog2(ROWS_MAX);
  localparam int RCNT_W   = ROW_W + 1;
  localparam int ANG_W    = $clog2(NUM_ANGLES);
  localparam int NCNT_W   = $clog2(NUM_ANGLES + 1);
  localparam int ADDR_W   = ROW_W + ANG_W;
  localparam int PIDX_W   = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int PCNT_W   = $clog2(MAX_PEAKS + 1);

  localparam int DIM_W    = 11;
  localparam int COL_W    = 10;
  localparam int PIX_W    = 8;
  localparam int THR_W    = 16;
  localparam int LINES_W  = 6;
  localparam int HALF_W   = ROW_W;
  localparam int RHO_W    = 13;
  localparam int ASTEP_W  = 8;
  localparam int CIDX_W   = 8;
  localparam int CDATA_W  = 16;

  localparam int TRIG_W   = 18;
  localparam int PROD_W   = COL_W + 1 + TRIG_W;
  localparam int BIAS_W   = PROD_W + 2;

  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned PI_HALF_Q30 = PI_Q30 / 2;

  typedef logic [VOTE_BITS-1:0] vote_t;
  typedef logic signed [TRIG_W-1:0] trig_tbl_t [NUM_ANGLES];

  localparam vote_t VOTE_MAX = '1;

  typedef enum logic [CIDX_W-1:0] {
    REG_WIDTH  = 8'd0,
    REG_HEIGHT = 8'd1,
    REG_THRESH = 8'd2,
    REG_LINES  = 8'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_BOOT,
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    vote_t             wdata;
  } mem_req_t;

  function automatic logic signed [TRIG_W-1:0] q30_to_q16(input longint v);
    longint unsigned u;
    u = (v < 0) ? 64'd0 : longint'(v);
    q30_to_q16 = TRIG_W'((u + 64'd8192) >> 14);
  endfunction

  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic trig_tbl_t gen_trig(input bit want_cos);
    trig_tbl_t         tbl;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   t;
    longint            ss;
    longint            cs;
    bit                neg;
    int unsigned       n;
    int unsigned       k;
    for (n = 0; n < NUM_ANGLES; n++) begin
      x   = udiv64(longint'(n) * PI_Q30, 64'(NUM_ANGLES));
      neg = 1'b0;
      if (x > PI_HALF_Q30) begin
        x   = PI_Q30 - x;
        neg = 1'b1;
      end
      x2 = (x * x) >> 30;
      ss = 0;
      cs = 0;
      t  = x;
      for (k = 0; k < 15; k++) begin
        ss = k[0] ? ss - longint'(t) : ss + longint'(t);
        t  = udiv64((t * x2) >> 30, longint'(2 * k + 2) * longint'(2 * k + 3));
      end
      t = ONE_Q30;
      for (k = 0; k < 15; k++) begin
        cs = k[0] ? cs - longint'(t) : cs + longint'(t);
        t  = udiv64((t * x2) >> 30, longint'(2 * k + 1) * longint'(2 * k + 2));
      end
      if (want_cos) begin
        tbl[n] = neg ? -q30_to_q16(cs) : q30_to_q16(cs);
      end else begin
        tbl[n] = q30_to_q16(ss);
      end
    end
    return tbl;
  endfunction

  localparam trig_tbl_t SIN_TBL = gen_trig(1'b0);
  localparam trig_tbl_t COS_TBL = gen_trig(1'b1);

endpackage

@@ rtl/hlpf_if.sv @@
`timescale 1ns / 1ps
interface hlpf_pix_if import hlpf_pkg::*;;
  logic             valid;
  logic             ready;
  logic             func;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] row;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, func, col, row, pixel, input ready);
  modport sink   (input valid, func, col, row, pixel, output ready);
endinterface

interface hlpf_res_if import hlpf_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [VOTE_BITS-1:0]     votes;
  logic signed [RHO_W-1:0]  rho_offset;
  logic [ASTEP_W-1:0]       angle_step;
  logic                     none_found;
  logic                     last;
  modport source (output valid, votes, rho_offset, angle_step, none_found, last,
                  input ready);
  modport sink   (input valid, votes, rho_offset, angle_step, none_found, last,
                  output ready);
endinterface

interface hlpf_cfg_if import hlpf_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/hough_line_peak_finder_unit.sv @@
`timescale 1ns / 1ps
// Hough line peak finder. A pixel transaction with a nonzero value inside the
// image does one read-modify-write of the vote memory per angle through its
// single read and single write port before the next pixel transaction is
// taken; one with a zero value or outside the image leaves the block idle and
// ready for the next. An end-of-frame transaction sweeps the whole vote memory
// once, finding peaks and zeroing cells as it goes, then hands out one result
// per cycle as the sink takes them. After reset the same sweep clears the vote
// memory, so no pixel transaction is taken until that sweep ends; configuration
// writes are taken at any time.
module hough_line_peak_finder_unit import hlpf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hlpf_pix_if.sink   pix_i,
  hlpf_res_if.source res_o,
  hlpf_cfg_if.sink   cfg_i
);

  state_e              state_q, state_d;
  logic [DIM_W-1:0]    width_q, height_q;
  vote_t               thr_q;
  logic [LINES_W-1:0]  lines_q;
  logic [DIM_W-1:0]    w_eff, h_eff;
  logic [HALF_W:0]     half;
  logic [RCNT_W-1:0]   rows;
  logic [PCNT_W-1:0]   cap;

  logic                pix_acc, vote_start, scan_start, scan_find, emit_load;
  logic                vote_busy, scan_busy;
  mem_req_t            vote_req, scan_req, mem_req;
  vote_t               mem_rdata;
  logic [PCNT_W-1:0]   count;
  vote_t               best_votes [MAX_PEAKS];
  logic [ROW_W-1:0]    best_row [MAX_PEAKS];
  logic [ANG_W-1:0]    best_ang [MAX_PEAKS];
  logic [PCNT_W-1:0]   k_q, k_d;
  logic                ov_q;
  logic                emit_last;

  always_comb begin
    w_eff = (width_q == '0) ? DIM_W'(1)
          : (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
    h_eff = (height_q == '0) ? DIM_W'(1)
          : (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
    half  = (HALF_W+1)'(w_eff) + (HALF_W+1)'(h_eff);
    rows  = RCNT_W'({half, 1'b0});
    cap   = (lines_q == '0) ? PCNT_W'(1)
          : (lines_q > LINES_W'(MAX_PEAKS)) ? PCNT_W'(MAX_PEAKS) : PCNT_W'(lines_q);
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1024);
      height_q <= DIM_W'(1024);
      thr_q    <= vote_t'(100);
      lines_q  <= LINES_W'(32);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_WIDTH:  width_q  <= cfg_i.data[DIM_W-1:0];
        REG_HEIGHT: height_q <= cfg_i.data[DIM_W-1:0];
        REG_THRESH: thr_q    <= cfg_i.data[VOTE_BITS-1:0];
        REG_LINES:  lines_q  <= cfg_i.data[LINES_W-1:0];
        default: ;
      endcase
    end
  end

  assign pix_i.ready = (state_q == ST_IDLE);
  assign pix_acc     = pix_i.valid && pix_i.ready;
  assign emit_last   = (count == '0) || (k_q == count - PCNT_W'(1));

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    vote_start = 1'b0;
    scan_start = 1'b0;
    scan_find  = 1'b0;
    emit_load  = 1'b0;
    unique case (state_q)
      ST_BOOT: begin
        scan_start = 1'b1;
        state_d    = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (!scan_busy) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (pix_acc) begin
          if (pix_i.func) begin
            scan_start = 1'b1;
            scan_find  = 1'b1;
            state_d    = ST_SCAN;
          end else if ((pix_i.pixel != '0) && (DIM_W'(pix_i.col) < w_eff)
                       && (DIM_W'(pix_i.row) < h_eff)) begin
            vote_start = 1'b1;
            state_d    = ST_VOTE;
          end
        end
      end
      ST_VOTE: begin
        if (!vote_busy) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        k_d = '0;
        if (!scan_busy) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ov_q || res_o.ready) begin
          emit_load = 1'b1;
          k_d       = k_q + PCNT_W'(1);
          if (emit_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BOOT;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (emit_load) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      res_o.last <= emit_last;
      if (count == '0) begin
        res_o.votes      <= '0;
        res_o.rho_offset <= '0;
        res_o.angle_step <= '0;
        res_o.none_found <= 1'b1;
      end else begin
        res_o.votes      <= best_votes[k_q[PIDX_W-1:0]];
        res_o.rho_offset <= RHO_W'($signed({1'b0, best_row[k_q[PIDX_W-1:0]]}))
                          - RHO_W'(half);
        res_o.angle_step <= ASTEP_W'(best_ang[k_q[PIDX_W-1:0]]);
        res_o.none_found <= 1'b0;
      end
    end
  end

  assign res_o.valid = ov_q;

  hlpf_vote u_vote (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (vote_start),
    .x_i     (pix_i.col),
    .y_i     (pix_i.row),
    .half_i  (half),
    .rows_i  (rows),
    .rdata_i (mem_rdata),
    .req_o   (vote_req),
    .busy_o  (vote_busy)
  );

  hlpf_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (scan_start),
    .find_i       (scan_find),
    .rows_i       (rows),
    .thr_i        (thr_q),
    .cap_i        (cap),
    .rdata_i      (mem_rdata),
    .req_o        (scan_req),
    .busy_o       (scan_busy),
    .count_o      (count),
    .best_votes_o (best_votes),
    .best_row_o   (best_row),
    .best_ang_o   (best_ang)
  );

  assign mem_req = (state_q == ST_VOTE) ? vote_req : scan_req;

  hlpf_ram #(.ADDR_W(ADDR_W), .DATA_W(VOTE_BITS)) u_votes (
    .clk_i   (clk_i),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata)
  );

endmodule

@@ rtl/hlpf_ram.sv @@
`timescale 1ns / 1ps
module hlpf_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/hlpf_vote.sv @@
`timescale 1ns / 1ps
module hlpf_vote import hlpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [COL_W-1:0]  x_i,
  input  logic [COL_W-1:0]  y_i,
  input  logic [HALF_W:0]   half_i,
  input  logic [RCNT_W-1:0] rows_i,
  input  vote_t             rdata_i,
  output mem_req_t          req_o,
  output logic              busy_o
);

  logic                     iss_q, iss_d;
  logic [NCNT_W-1:0]        n_q, n_d;
  logic [COL_W-1:0]         x_q, y_q;
  logic                     p1_q;
  logic [ANG_W-1:0]         p1_n_q;
  logic signed [PROD_W-1:0] px_q, py_q;
  logic                     p2_q;
  logic [ADDR_W-1:0]        p2_addr_q;
  logic signed [BIAS_W-1:0] biased;
  logic                     hit;

  always_comb begin
    iss_d = iss_q;
    n_d   = n_q;
    if (start_i) begin
      iss_d = 1'b1;
      n_d   = '0;
    end else if (iss_q) begin
      n_d = n_q + NCNT_W'(1);
      if (n_q == NCNT_W'(NUM_ANGLES - 1)) begin
        iss_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= 1'b0;
      n_q   <= '0;
      p1_q  <= 1'b0;
      p2_q  <= 1'b0;
    end else begin
      iss_q <= iss_d;
      n_q   <= n_d;
      p1_q  <= iss_q;
      p2_q  <= p1_q && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      y_q <= y_i;
    end
    px_q      <= $signed({1'b0, x_q}) * COS_TBL[n_q[ANG_W-1:0]];
    py_q      <= $signed({1'b0, y_q}) * SIN_TBL[n_q[ANG_W-1:0]];
    p1_n_q    <= n_q[ANG_W-1:0];
    p2_addr_q <= {biased[16+ROW_W-1:16], p1_n_q};
  end

  always_comb begin
    biased = BIAS_W'(px_q) + BIAS_W'(py_q) + BIAS_W'(32768)
           + BIAS_W'($signed({1'b0, half_i, 16'd0}));
    hit    = !biased[BIAS_W-1] && (biased[BIAS_W-2:16] < (BIAS_W-17)'(rows_i));
  end

  always_comb begin
    req_o.re    = p1_q && hit;
    req_o.raddr = {biased[16+ROW_W-1:16], p1_n_q};
    req_o.we    = p2_q && (rdata_i != VOTE_MAX);
    req_o.waddr = p2_addr_q;
    req_o.wdata = rdata_i + vote_t'(1);
  end

  assign busy_o = iss_q || p1_q || p2_q;

endmodule

@@ rtl/hlpf_scan.sv @@
`timescale 1ns / 1ps
module hlpf_scan import hlpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              find_i,
  input  logic [RCNT_W-1:0] rows_i,
  input  vote_t             thr_i,
  input  logic [PCNT_W-1:0] cap_i,
  input  vote_t             rdata_i,
  output mem_req_t          req_o,
  output logic              busy_o,
  output logic [PCNT_W-1:0] count_o,
  output vote_t             best_votes_o [MAX_PEAKS],
  output logic [ROW_W-1:0]  best_row_o [MAX_PEAKS],
  output logic [ANG_W-1:0]  best_ang_o [MAX_PEAKS]
);

  logic                   iss_q, find_q;
  logic [RCNT_W-1:0]      r_q;
  logic [NCNT_W-1:0]      n_q;
  logic                   s1_q;
  logic [RCNT_W-1:0]      s1_r_q;
  logic [NCNT_W-1:0]      s1_n_q;
  vote_t                  c1_q, c2_q, u1_q, d1_q;
  logic                   cand_q;
  vote_t                  cv_q;
  logic [ROW_W-1:0]       cr_q;
  logic [ANG_W-1:0]       cn_q;
  logic [PCNT_W-1:0]      count_q;
  vote_t                  bv_q [MAX_PEAKS];
  logic [ROW_W-1:0]       br_q [MAX_PEAKS];
  logic [ANG_W-1:0]       bn_q [MAX_PEAKS];

  logic                   lb_re, lb_we, s1_col_ok;
  logic [2*VOTE_BITS-1:0] lb_rdata, lb_word;
  vote_t                  d_val, up_val, cen_val, left_val;
  logic                   peak;
  logic [MAX_PEAKS-1:0]   ge;
  logic [PCNT_W-1:0]      at;

  assign lb_re     = iss_q && (n_q < NCNT_W'(NUM_ANGLES));
  assign s1_col_ok = s1_n_q < NCNT_W'(NUM_ANGLES);
  assign lb_we     = s1_q && s1_col_ok;

  hlpf_ram #(.ADDR_W(ANG_W), .DATA_W(2 * VOTE_BITS)) u_line (
    .clk_i   (clk_i),
    .re_i    (lb_re),
    .raddr_i (n_q[ANG_W-1:0]),
    .rdata_o (lb_rdata),
    .we_i    (lb_we),
    .waddr_i (s1_n_q[ANG_W-1:0]),
    .wdata_i ({cen_val, d_val})
  );

  always_comb begin
    d_val    = (s1_col_ok && (s1_r_q < rows_i)) ? rdata_i : '0;
    lb_word  = (s1_col_ok && (s1_r_q != '0)) ? lb_rdata : '0;
    up_val   = lb_word[2*VOTE_BITS-1:VOTE_BITS];
    cen_val  = lb_word[VOTE_BITS-1:0];
    left_val = (s1_n_q >= NCNT_W'(2)) ? c2_q : '0;
    peak     = s1_q && find_q && (s1_r_q != '0) && (s1_r_q <= rows_i)
            && (s1_n_q != '0) && (c1_q > thr_i) && (c1_q > u1_q) && (c1_q > d1_q)
            && (c1_q > left_val) && (c1_q > cen_val);
  end

  always_comb begin
    req_o.re    = iss_q && (n_q < NCNT_W'(NUM_ANGLES)) && (r_q < RCNT_W'(ROWS_MAX));
    req_o.raddr = {r_q[ROW_W-1:0], n_q[ANG_W-1:0]};
    req_o.we    = s1_q && s1_col_ok && (s1_r_q < RCNT_W'(ROWS_MAX));
    req_o.waddr = {s1_r_q[ROW_W-1:0], s1_n_q[ANG_W-1:0]};
    req_o.wdata = '0;
  end

  always_comb begin
    for (int i = 0; i < MAX_PEAKS; i++) begin
      ge[i] = (PCNT_W'(i) < count_q) && (bv_q[i] >= cv_q);
    end
    at = PCNT_W'($countones(ge));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q   <= 1'b0;
      find_q  <= 1'b0;
      r_q     <= '0;
      n_q     <= '0;
      s1_q    <= 1'b0;
      cand_q  <= 1'b0;
      count_q <= '0;
    end else begin
      s1_q   <= iss_q;
      cand_q <= peak;
      if (start_i) begin
        iss_q   <= 1'b1;
        find_q  <= find_i;
        r_q     <= '0;
        n_q     <= '0;
        count_q <= '0;
      end else begin
        if (iss_q) begin
          if (n_q == NCNT_W'(NUM_ANGLES)) begin
            n_q <= '0;
            if (r_q == RCNT_W'(ROWS_MAX)) begin
              iss_q <= 1'b0;
            end else begin
              r_q <= r_q + RCNT_W'(1);
            end
          end else begin
            n_q <= n_q + NCNT_W'(1);
          end
        end
        if (cand_q && (at < cap_i) && (count_q < cap_i)) begin
          count_q <= count_q + PCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_r_q <= r_q;
    s1_n_q <= n_q;
    if (s1_q) begin
      c2_q <= c1_q;
      c1_q <= cen_val;
      u1_q <= up_val;
      d1_q <= d_val;
    end
    cv_q <= c1_q;
    cr_q <= ROW_W'(s1_r_q - RCNT_W'(1));
    cn_q <= ANG_W'(s1_n_q - NCNT_W'(1));
    if (cand_q && (at < cap_i)) begin
      for (int i = 0; i < MAX_PEAKS; i++) begin
        if (PCNT_W'(i) == at) begin
          bv_q[i] <= cv_q;
          br_q[i] <= cr_q;
          bn_q[i] <= cn_q;
        end else if ((PCNT_W'(i) > at) && (i > 0)) begin
          bv_q[i] <= bv_q[(i > 0) ? i - 1 : 0];
          br_q[i] <= br_q[(i > 0) ? i - 1 : 0];
          bn_q[i] <= bn_q[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  assign busy_o       = iss_q || s1_q || cand_q;
  assign count_o      = count_q;
  assign best_votes_o = bv_q;
  assign best_row_o   = br_q;
  assign best_ang_o   = bn_q;

endmodule

@@ rtl/hlpf_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hlpf_checker import hlpf_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    pix_valid_i,
  input logic                    pix_ready_i,
  input logic                    pix_func_i,
  input logic                    res_valid_i,
  input logic                    res_ready_i,
  input logic [VOTE_BITS-1:0]    res_votes_i,
  input logic signed [RHO_W-1:0] res_rho_i,
  input logic [ASTEP_W-1:0]      res_angle_i,
  input logic                    res_none_i,
  input logic                    res_last_i
);

  `AST_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i)
  `AST_NOW(a_none_last, res_valid_i && res_none_i, res_last_i && (res_votes_i == '0))
  `AST_NOW(a_none_zero, res_valid_i && res_none_i, (res_rho_i == '0) && (res_angle_i == '0))
  `AST_NEXT(a_frame_busy, pix_valid_i && pix_ready_i && pix_func_i, !pix_ready_i)

endmodule

bind hough_line_peak_finder_unit hlpf_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .pix_func_i  (pix_i.func),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_votes_i (res_o.votes),
  .res_rho_i   (res_o.rho_offset),
  .res_angle_i (res_o.angle_step),
  .res_none_i  (res_o.none_found),
  .res_last_i  (res_o.last)
);
